/* rtl/cds_pkg.sv */
// Shared types, codes and default sizes for the circular-scan disk request scheduler.
// No dependencies; cds_if and the scheduler in rtl/ import this package, cds_ram does not.
package cds_pkg;

    localparam int C_QUEUE_DEPTH      = 16;
    localparam int C_BLOCKS_PER_TRACK = 16;

    localparam int C_TRACK_W  = 12;
    localparam int C_BLOCK_W  = 8;
    localparam int C_COUNT_W  = 8;
    localparam int C_TAG_W    = 6;
    localparam int C_STATUS_W = 3;

    localparam logic OP_ENQUEUE  = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [C_STATUS_W-1:0] {
        ST_DISPATCHED = 3'd0,
        ST_ENQUEUED   = 3'd1,
        ST_FULL       = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_INVALID    = 3'd4
    } t_status;

    typedef struct packed {
        logic [C_TRACK_W-1:0] track;
        logic [C_BLOCK_W-1:0] block;
        logic [C_COUNT_W-1:0] count;
        logic                 write;
        logic [C_TAG_W-1:0]   tag;
    } t_req;

    typedef struct packed {
        t_status status;
        t_req    req;
        logic    wrapped;
    } t_rsp;

endpackage

/* rtl/cds_if.sv */
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on cds_pkg for field widths.
interface cds_req_if
    import cds_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [C_TRACK_W-1:0] req_track;
    logic [C_BLOCK_W-1:0] req_block;
    logic [C_COUNT_W-1:0] req_count;
    logic                 req_write;
    logic [C_TAG_W-1:0]   req_tag;

    modport source (output valid, op, req_track, req_block, req_count, req_write, req_tag,
                    input ready);
    modport sink (input valid, op, req_track, req_block, req_count, req_write, req_tag,
                  output ready);
endinterface

interface cds_rsp_if
    import cds_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [C_STATUS_W-1:0] status;
    logic [C_TRACK_W-1:0]  out_track;
    logic [C_BLOCK_W-1:0]  out_block;
    logic [C_COUNT_W-1:0]  out_count;
    logic                  out_write;
    logic [C_TAG_W-1:0]    out_tag;
    logic                  wrapped;

    modport source (output valid, status, out_track, out_block, out_count, out_write,
                    out_tag, wrapped, input ready);
    modport sink (input valid, status, out_track, out_block, out_count, out_write,
                  out_tag, wrapped, output ready);
endinterface

/* rtl/cscan_disk_request_scheduler.sv */
// Enqueue, or a dispatch on an empty table: the request is registered and handled in S_EXEC,
// and the result passes through S_DONE into the output register; S_IDLE takes the next transfer.
// Dispatch: one pass over the entry RAM picks the request with two track/age comparators,
// one for tracks at or above the head and one for the wrap to track zero; a second pass
// ages down the younger entries. S_DONE holds a result while the previous one waits for ready.
// One item at a time. Synchronous reset clears valid bits and head track; no clearing pass.
module cscan_disk_request_scheduler
    import cds_pkg::*;
#(
    parameter int QUEUE_DEPTH      = C_QUEUE_DEPTH,
    parameter int BLOCKS_PER_TRACK = C_BLOCKS_PER_TRACK
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cds_req_if.sink    i_req,
    cds_rsp_if.source  o_rsp
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $bits(t_req) + IW;
    localparam logic [CW-1:0] LAST = CW'(QUEUE_DEPTH);
    localparam logic [C_BLOCK_W:0] BPT = (C_BLOCK_W + 1)'(BLOCKS_PER_TRACK);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_PICK,
        S_AGE,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [C_TRACK_W-1:0]   r_head;
    logic                   r_op;
    t_req                   r_in;
    logic [CW-1:0]          r_cnt;
    logic [IW-1:0]          r_pidx;
    logic                   r_a_hit, r_b_hit;
    t_req                   r_a_req, r_b_req;
    logic [IW-1:0]          r_a_age, r_b_age, r_a_slot, r_b_slot;
    logic [IW-1:0]          r_pick_age;
    t_rsp                   r_res;
    t_rsp                   r_out;
    logic                   r_out_valid;

    logic [RW-1:0] ram_rdata, ram_wdata;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic          ram_we;
    t_req          rd_req;
    logic [IW-1:0] rd_age;

    logic [IW-1:0] free_slot;
    logic          full;
    logic [CW-1:0] used_cnt;
    logic          in_bad;
    logic          proc;
    logic          n_a_take, n_b_take;
    logic          age_dec;

    // Lower track wins, older entry on equal tracks.
    function automatic logic better(input logic [C_TRACK_W-1:0] trk, input logic [IW-1:0] age,
                                    input logic [C_TRACK_W-1:0] best_trk,
                                    input logic [IW-1:0] best_age);
        better = (trk < best_trk) || ((trk == best_trk) && (age < best_age));
    endfunction

    cds_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_req    = t_req'(ram_rdata[RW-1:IW]);
    assign rd_age    = ram_rdata[IW-1:0];
    assign ram_raddr = r_cnt[IW-1:0];

    always_comb begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IW'(i);
            end
        end
    end

    assign full     = &r_valid;
    assign used_cnt = CW'($countones(r_valid));
    assign in_bad   = (r_in.count == '0) || ({1'b0, r_in.block} >= BPT);

    // Read data is registered in the RAM, and r_pidx is the registered address, so r_pidx names the entry on ram_rdata.
    assign proc     = (r_cnt != '0) && r_valid[r_pidx];
    assign n_a_take = proc && (rd_req.track >= r_head) &&
                      (!r_a_hit || better(rd_req.track, rd_age, r_a_req.track, r_a_age));
    assign n_b_take = proc &&
                      (!r_b_hit || better(rd_req.track, rd_age, r_b_req.track, r_b_age));
    assign age_dec  = proc && (rd_age > r_pick_age);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = {rd_req, rd_age - 1'b1};
        unique case (r_state)
            S_EXEC: begin
                ram_we    = (r_op == OP_ENQUEUE) && !in_bad && !full;
                ram_waddr = free_slot;
                ram_wdata = {r_in, used_cnt[IW-1:0]};
            end
            S_AGE: begin
                ram_we = age_dec;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_a_hit     <= 1'b0;
            r_b_hit     <= 1'b0;
        end else begin
            r_pidx <= r_cnt[IW-1:0];
            if ((r_state == S_DONE) && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op       <= i_req.op;
                        r_in.track <= i_req.req_track;
                        r_in.block <= i_req.req_block;
                        r_in.count <= i_req.req_count;
                        r_in.write <= i_req.req_write;
                        r_in.tag   <= i_req.req_tag;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_ENQUEUE) begin
                        r_state <= S_DONE;
                        if (in_bad) begin
                            r_res <= '{status: ST_INVALID, req: '0, wrapped: 1'b0};
                        end else if (full) begin
                            r_res <= '{status: ST_FULL, req: '0, wrapped: 1'b0};
                        end else begin
                            r_valid[free_slot] <= 1'b1;
                            r_res <= '{status: ST_ENQUEUED, req: '0, wrapped: 1'b0};
                        end
                    end else if (r_valid != '0) begin
                        r_cnt   <= '0;
                        r_a_hit <= 1'b0;
                        r_b_hit <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_res   <= '{status: ST_EMPTY, req: '0, wrapped: 1'b0};
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (n_a_take) begin
                        r_a_hit  <= 1'b1;
                        r_a_req  <= rd_req;
                        r_a_age  <= rd_age;
                        r_a_slot <= r_pidx;
                    end
                    if (n_b_take) begin
                        r_b_hit  <= 1'b1;
                        r_b_req  <= rd_req;
                        r_b_age  <= rd_age;
                        r_b_slot <= r_pidx;
                    end
                    if (r_cnt == LAST) begin
                        r_state <= S_PICK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_PICK: begin
                    // Wrap to track zero when nothing sits at or above the head.
                    if (r_a_hit) begin
                        r_valid[r_a_slot] <= 1'b0;
                        r_head            <= r_a_req.track;
                        r_pick_age        <= r_a_age;
                        r_res             <= '{status: ST_DISPATCHED, req: r_a_req,
                                               wrapped: 1'b0};
                    end else begin
                        r_valid[r_b_slot] <= 1'b0;
                        r_head            <= r_b_req.track;
                        r_pick_age        <= r_b_age;
                        r_res             <= '{status: ST_DISPATCHED, req: r_b_req,
                                               wrapped: 1'b1};
                    end
                    r_cnt   <= '0;
                    r_state <= S_AGE;
                end
                S_AGE: begin
                    if (r_cnt == LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    // Hold the result until the output register is free.
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.out_track = r_out.req.track;
    assign o_rsp.out_block = r_out.req.block;
    assign o_rsp.out_count = r_out.req.count;
    assign o_rsp.out_write = r_out.req.write;
    assign o_rsp.out_tag   = r_out.req.tag;
    assign o_rsp.wrapped   = r_out.wrapped;
endmodule

/* rtl/cds_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module cds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* dv/cscan_disk_request_scheduler_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the circular-scan disk request scheduler: watches both channels,
// predicts every response from its own copy of the request table and compares.
// Depends on cds_pkg and the channel interfaces in cds_if.
module cscan_disk_request_scheduler_checker
    import cds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cds_req_if   i_req,
    cds_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_pending
);

    localparam int AGE_W = $clog2(C_QUEUE_DEPTH);

    logic                 slot_used [C_QUEUE_DEPTH];
    t_req                 slot_req  [C_QUEUE_DEPTH];
    logic [AGE_W-1:0]     slot_age  [C_QUEUE_DEPTH];
    logic [C_TRACK_W-1:0] head;
    t_rsp                 sched_rsp_q[$];
    int                   mismatch_cnt = 0;
    int                   pending_cnt = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_cnt;

    task automatic report(input string msg);
        $display("%0t %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report($sformatf("%s: got %0h, want %0h", name, got, want));
        end
    endtask

    // Lowest track at or above the floor; oldest entry wins a tie.
    function automatic int nearest_slot(input logic [C_TRACK_W-1:0] floor_trk);
        int best;
        best = -1;
        for (int i = 0; i < C_QUEUE_DEPTH; i++) begin
            if (slot_used[i] && slot_req[i].track >= floor_trk) begin
                if (best < 0 || slot_req[i].track < slot_req[best].track ||
                    (slot_req[i].track == slot_req[best].track &&
                     slot_age[i] < slot_age[best])) begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    // Apply one request to the table and return the response it must produce.
    function automatic t_rsp schedule(input logic op, input t_req rq);
        t_rsp             rsp;
        int               pick;
        int               free_slot;
        int               used;
        logic [AGE_W-1:0] gone_age;
        rsp = '0;
        if (op == OP_ENQUEUE) begin
            if (rq.count == '0 || rq.block >= C_BLOCKS_PER_TRACK) begin
                rsp.status = ST_INVALID;
                return rsp;
            end
            free_slot = -1;
            used = 0;
            for (int i = 0; i < C_QUEUE_DEPTH; i++) begin
                if (slot_used[i]) begin
                    used++;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0) begin
                rsp.status = ST_FULL;
                return rsp;
            end
            slot_used[free_slot] = 1'b1;
            slot_req[free_slot]  = rq;
            slot_age[free_slot]  = AGE_W'(used);
            rsp.status = ST_ENQUEUED;
            return rsp;
        end
        pick = nearest_slot(head);
        if (pick < 0) begin
            // nothing ahead of the head: wrap to track zero
            pick = nearest_slot('0);
            if (pick < 0) begin
                rsp.status = ST_EMPTY;
                return rsp;
            end
            rsp.wrapped = 1'b1;
        end
        gone_age = slot_age[pick];
        slot_used[pick] = 1'b0;
        for (int i = 0; i < C_QUEUE_DEPTH; i++) begin
            if (slot_used[i] && slot_age[i] > gone_age) begin
                slot_age[i]--;
            end
        end
        head = slot_req[pick].track;
        rsp.status = ST_DISPATCHED;
        rsp.req = slot_req[pick];
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_req rq;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            head = '0;
            sched_rsp_q.delete();
        end else begin
            // retire the response first; it always belongs to an older transfer
            if (i_rsp.valid && i_rsp.ready) begin
                if (sched_rsp_q.size() == 0) begin
                    report($sformatf("response with status %0d while none is due",
                                     i_rsp.status));
                end else begin
                    want = sched_rsp_q.pop_front();
                    check_field("status", 16'(i_rsp.status), 16'(want.status));
                    check_field("out_track", 16'(i_rsp.out_track), 16'(want.req.track));
                    check_field("out_block", 16'(i_rsp.out_block), 16'(want.req.block));
                    check_field("out_count", 16'(i_rsp.out_count), 16'(want.req.count));
                    check_field("out_write", 16'(i_rsp.out_write), 16'(want.req.write));
                    check_field("out_tag", 16'(i_rsp.out_tag), 16'(want.req.tag));
                    check_field("wrapped", 16'(i_rsp.wrapped), 16'(want.wrapped));
                end
            end
            if (i_req.valid && i_req.ready) begin
                rq = '{track: i_req.req_track, block: i_req.req_block,
                       count: i_req.req_count, write: i_req.req_write,
                       tag: i_req.req_tag};
                sched_rsp_q.push_back(schedule(i_req.op, rq));
            end
        end
        pending_cnt <= sched_rsp_q.size();
    end

endmodule

/* dv/cscan_disk_request_scheduler_tb.sv */
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, request stimulus and response stalls.
// Depends on cds_pkg, cds_if, the scheduler RTL and cscan_disk_request_scheduler_checker.
module cscan_disk_request_scheduler_tb;
    import cds_pkg::*;

    localparam int DISPATCH_CYCLES = 2 * C_QUEUE_DEPTH + 5;
    localparam int RANDOM_ITEMS    = 950;

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    int   mismatches;
    int   pending;

    cds_req_if req_if ();
    cds_rsp_if rsp_if ();

    cscan_disk_request_scheduler DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    cscan_disk_request_scheduler_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("cscan_disk_request_scheduler: mismatch");
        $finish;
    end

    // Response side: stall at random except during the quiet stretch.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= i_rst_n && !(idle_on && $urandom_range(0, 99) < 11);
        end
    end

    // Hold valid until the transfer; valid stays high when the next item follows directly.
    task automatic send(input logic op, input t_req rq);
        while (idle_on && $urandom_range(0, 99) < 11) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= op;
        req_if.req_track <= rq.track;
        req_if.req_block <= rq.block;
        req_if.req_count <= rq.count;
        req_if.req_write <= rq.write;
        req_if.req_tag   <= rq.tag;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic enqueue(input int trk, input int blk, input int cnt, input int wr,
                           input int tag);
        send(OP_ENQUEUE, '{track: C_TRACK_W'(trk), block: C_BLOCK_W'(blk),
                           count: C_COUNT_W'(cnt), write: wr[0], tag: C_TAG_W'(tag)});
    endtask

    // Request fields are don't-care on a dispatch; fill them with noise.
    task automatic dispatch();
        send(OP_DISPATCH, t_req'({$urandom, $urandom}));
    endtask

    // Stop sending until every outstanding response has been taken.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_item(input int enq_pct);
        t_req rq;
        case ($urandom_range(0, 3))
            0:       rq.track = C_TRACK_W'($urandom);
            1:       rq.track = {C_TRACK_W{1'b1}};
            default: rq.track = C_TRACK_W'($urandom_range(0, 7) << 9);
        endcase
        rq.block = C_BLOCK_W'($urandom_range(0, C_BLOCKS_PER_TRACK - 1));
        rq.count = C_COUNT_W'($urandom_range(1, 255));
        rq.write = 1'($urandom);
        rq.tag   = C_TAG_W'($urandom);
        // a few malformed requests: zero count, block past the track, or random count and block
        if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
                0:       rq.count = '0;
                1:       rq.block = C_BLOCK_W'($urandom_range(C_BLOCKS_PER_TRACK, 255));
                default: begin
                    rq.count = C_COUNT_W'($urandom);
                    rq.block = C_BLOCK_W'($urandom);
                end
            endcase
        end
        if ($urandom_range(0, 99) < enq_pct) begin
            send(OP_ENQUEUE, rq);
        end else begin
            dispatch();
        end
    endtask

    initial begin
        int enq_pct;
        idle_on          <= 1'b1;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.op        <= OP_ENQUEUE;
        req_if.req_track <= '0;
        req_if.req_block <= '0;
        req_if.req_count <= '0;
        req_if.req_write <= 1'b0;
        req_if.req_tag   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, malformed requests, field extremes, tie, wrap
        dispatch();
        enqueue(100, 0, 0, 0, 0);
        enqueue(100, C_BLOCKS_PER_TRACK, 5, 0, 0);
        enqueue(4095, 255, 0, 1, 63);
        enqueue(4095, C_BLOCKS_PER_TRACK - 1, 255, 1, 63);
        enqueue(0, 0, 1, 0, 0);
        enqueue(100, 3, 8, 1, 21);
        enqueue(100, 7, 9, 0, 42);
        enqueue(2048, 8, 128, 1, 1);
        repeat (5) dispatch();
        enqueue(5, 1, 2, 0, 7);
        dispatch();
        dispatch();
        drain();

        enq_pct = 85;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // swing occupancy between full and empty in phases
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            end
            if (i > 0 && i % 250 == 0) begin
                drain();
            end
            idle_on <= !(i >= 400 && i < 600);
            random_item(enq_pct);
        end

        drain();
        repeat (DISPATCH_CYCLES + 10) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("cscan_disk_request_scheduler: match");
        end else begin
            $display("cscan_disk_request_scheduler: mismatch");
        end
        $finish;
    end

endmodule
